[src/wps_pkg.sv]
// Shared types, constants and helper functions for the wildcard pattern scanner.
// Depends on nothing; every other file in src/ uses it by scoped names.
package wps_pkg;

  // Pattern storage
  localparam int PAT_BYTES   = 8;
  localparam int AGE_W       = (PAT_BYTES > 1) ? $clog2(PAT_BYTES) : 1;
  localparam int WIN_DEPTH   = (PAT_BYTES > 1) ? PAT_BYTES - 1 : 1;

  // Field widths
  localparam int LEN_W       = 4;
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;

  localparam logic [3:0]         NIB_MASK  = 4'hF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Event queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES     = 3'd0,
    REG_NIBBLE_CARE       = 3'd1,
    REG_PATTERN_LENGTH    = 3'd2,
    REG_BASE_ADDRESS      = 3'd3,
    REG_MATCH_OFFSET      = 3'd4,
    REG_WANTED_OCCURRENCE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0]        pattern_bytes;
    logic [15:0]        nibble_care;
    logic [LEN_W-1:0]   pattern_length;
    logic [ADDR_W-1:0]  base_address;
    logic [ADDR_W-1:0]  match_offset;
    logic [COUNT_W-1:0] wanted_occurrence;
  } cfg_t;

  // One classified byte: a pattern hit ending here and/or end of region
  typedef struct packed {
    logic              hit;
    logic              last;
    logic [ADDR_W-1:0] start;
  } scan_event_t;

  // Queue status seen by the input handshake and the back
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // Pattern byte compare; a clear care bit makes that nibble a wildcard
  function automatic logic byte_ok(input logic [7:0] pb, input logic [1:0] care,
                                   input logic [7:0] b);
    logic ok;
    ok = 1'b1;
    if (care[0] && ((b[3:0] & NIB_MASK) != (pb[3:0] & NIB_MASK))) ok = 1'b0;
    if (care[1] && ((b[7:4] & NIB_MASK) != (pb[7:4] & NIB_MASK))) ok = 1'b0;
    return ok;
  endfunction

endpackage

[src/wildcard_pattern_scan_core.sv]
// Top level of the nibble-wildcard byte signature scanner.
// Depends on wps_pkg, wps_front, wps_queue and wps_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one scanned byte per word, data_byte
//   plus last_byte marking the final byte of a region. A word is taken at a
//   clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): at most one word per region;
//   found=1 with match_address = base + match start + offset when the selected
//   occurrence completes, or found=0 with address 0 on the last byte if it
//   never did. The last byte also restarts the scan.
//   Configuration (cfg_write_en / cfg_index / cfg_data): written while idle.
// Timing:
//   One byte per cycle sustained while in_stall is low. The front compares all
//   pattern bytes in parallel in the cycle a byte is taken; the event passes a
//   two-entry queue and the back registers the result in its output register.
//   in_stall rises only when the queue is full, which happens only while
//   out_stall holds a pending result.
// Reset (rst, synchronous): registers return to their defaults (length 1,
//   others 0), the scan state and queue clear and no result is pending.
module wildcard_pattern_scan_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [wps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             found,
  output logic [wps_pkg::ADDR_W-1:0]       match_address
);

  wps_pkg::cfg_t          cfg;
  wps_pkg::scan_event_t   ev;
  wps_pkg::scan_event_t   head;
  wps_pkg::queue_status_t q_status;
  logic                   accept;
  logic                   ev_push;
  logic                   pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes     <= '0;
      cfg.nibble_care       <= '0;
      cfg.pattern_length    <= wps_pkg::LEN_W'(1);
      cfg.base_address      <= '0;
      cfg.match_offset      <= '0;
      cfg.wanted_occurrence <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        wps_pkg::REG_PATTERN_BYTES:     cfg.pattern_bytes     <= cfg_data;
        wps_pkg::REG_NIBBLE_CARE:       cfg.nibble_care       <= cfg_data[15:0];
        wps_pkg::REG_PATTERN_LENGTH:    cfg.pattern_length    <= cfg_data[wps_pkg::LEN_W-1:0];
        wps_pkg::REG_BASE_ADDRESS:      cfg.base_address      <= cfg_data[wps_pkg::ADDR_W-1:0];
        wps_pkg::REG_MATCH_OFFSET:      cfg.match_offset      <= cfg_data[wps_pkg::ADDR_W-1:0];
        wps_pkg::REG_WANTED_OCCURRENCE: begin
          cfg.wanted_occurrence <= cfg_data[wps_pkg::COUNT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Input handshake
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  wps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .ev_push   (ev_push),
    .ev        (ev)
  );

  wps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_data (ev),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  wps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_address (match_address)
  );

endmodule

[src/wps_front.sv]
// Front end of the scanner: byte window, fill count, position and pattern compare.
// Depends on wps_pkg; emits one scan event per hit or region end.
module wps_front (
  input  logic                clk,
  input  logic                rst,
  input  wps_pkg::cfg_t       cfg,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                ev_push,
  output wps_pkg::scan_event_t ev
);

  logic [7:0]                 window [wps_pkg::WIN_DEPTH];
  logic [7:0]                 ages   [wps_pkg::PAT_BYTES];
  logic [wps_pkg::LEN_W-1:0]  fill;
  logic [wps_pkg::LEN_W-1:0]  fill_next;
  logic [wps_pkg::LEN_W-1:0]  len_eff;
  logic [wps_pkg::ADDR_W-1:0] pos;
  logic                       hit;

  // Clamp the length to the window size
  always_comb begin
    if (cfg.pattern_length > wps_pkg::LEN_W'(wps_pkg::PAT_BYTES)) begin
      len_eff = wps_pkg::LEN_W'(wps_pkg::PAT_BYTES);
    end else begin
      len_eff = cfg.pattern_length;
    end
    fill_next = (fill < wps_pkg::LEN_W'(wps_pkg::PAT_BYTES)) ? fill + 1'b1 : fill;
  end

  // Age 0 is the current byte, age k is the byte k steps back
  always_comb begin
    ages[0] = data_byte;
    for (int k = 1; k < wps_pkg::PAT_BYTES; k++) begin
      ages[k] = window[k-1];
    end
  end

  // Pattern byte i lines up with age len-1-i; all lanes compare in parallel
  always_comb begin
    logic [wps_pkg::LEN_W-1:0] idx;
    idx = '0;
    hit = (len_eff != '0) && (fill_next >= len_eff);
    for (int i = 0; i < wps_pkg::PAT_BYTES; i++) begin
      if (wps_pkg::LEN_W'(i) < len_eff) begin
        idx = len_eff - wps_pkg::LEN_W'(i) - 1'b1;
        if (!wps_pkg::byte_ok(cfg.pattern_bytes[8*i +: 8], cfg.nibble_care[2*i +: 2],
                              ages[idx[wps_pkg::AGE_W-1:0]])) begin
          hit = 1'b0;
        end
      end
    end
  end

  // Event word to the queue
  assign ev.hit   = hit;
  assign ev.last  = last_byte;
  assign ev.start = pos - (wps_pkg::ADDR_W'(len_eff) - 1'b1);
  assign ev_push  = accept && (hit || last_byte);

  // Position and fill; the last byte restarts the region
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pos  <= '0;
    end else if (accept) begin
      if (last_byte) begin
        fill <= '0;
        pos  <= '0;
      end else begin
        fill <= fill_next;
        pos  <= pos + 1'b1;
      end
    end
  end

  // Byte window shift; entries beyond the fill count are never compared
  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      window[0] <= data_byte;
      for (int k = 1; k < wps_pkg::WIN_DEPTH; k++) begin
        window[k] <= window[k-1];
      end
    end
  end

endmodule

[src/wps_queue.sv]
// Short register queue of scan events between the front and back ends.
// Depends on wps_pkg for the event type and depth.
module wps_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  wps_pkg::scan_event_t  push_data,
  input  logic                  pop,
  output wps_pkg::scan_event_t  head,
  output wps_pkg::queue_status_t status
);

  wps_pkg::scan_event_t         entries [wps_pkg::QUEUE_DEPTH];
  logic [wps_pkg::QPTR_W-1:0]   wr_ptr;
  logic [wps_pkg::QPTR_W-1:0]   rd_ptr;
  logic [wps_pkg::QCNT_W-1:0]   count;

  assign head         = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == wps_pkg::QCNT_W'(wps_pkg::QUEUE_DEPTH));

  // Pointer step with wrap at the depth
  function automatic logic [wps_pkg::QPTR_W-1:0] ptr_inc(
      input logic [wps_pkg::QPTR_W-1:0] p);
    return (p == wps_pkg::QPTR_W'(wps_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full && !pop))
    else $error("event queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("event queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= wps_pkg::QCNT_W'(wps_pkg::QUEUE_DEPTH))
    else $error("event queue count out of range");

endmodule

[src/wps_back.sv]
// Back end of the scanner: match counting, report selection and the output register.
// Depends on wps_pkg; drains events from wps_queue.
module wps_back (
  input  logic                  clk,
  input  logic                  rst,
  input  wps_pkg::cfg_t         cfg,
  input  wps_pkg::scan_event_t  head,
  input  wps_pkg::queue_status_t q_status,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  found,
  output logic [wps_pkg::ADDR_W-1:0] match_address
);

  logic [wps_pkg::COUNT_W-1:0] seen;
  logic                        reported;
  logic                        sel;
  logic                        emit;

  // Take an event when the output register is free or being drained
  assign pop  = !q_status.empty && (!out_valid || !out_stall);
  assign sel  = head.hit && !reported && (seen == cfg.wanted_occurrence);
  assign emit = sel || (head.last && !reported);

  // Count and report state; region end clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      reported <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        seen     <= '0;
        reported <= 1'b0;
      end else if (sel) begin
        reported <= 1'b1;
      end else if (head.hit && !reported && (seen != wps_pkg::COUNT_MAX)) begin
        seen <= seen + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      found         <= sel;
      match_address <= sel ? cfg.base_address + head.start + cfg.match_offset : '0;
    end
  end

  a_miss_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_address == '0))
    else $error("miss result carries a nonzero address");
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (pop && emit) |=> out_valid)
    else $error("emitted result not held in output register");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> (!reported && (seen == '0)))
    else $error("region end did not clear scan state");
  a_pop_only_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> !(out_valid && out_stall))
    else $error("event taken while result is stalled");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for wildcard_pattern_scan_core: directed and random regions,
// checked word by word against an in-bench scan predictor with random idling on both sides.
// Depends on wps_pkg (register indexes, widths) and the RTL under src/.
`timescale 1ns / 100ps

module tb_top;

  localparam int WIN_BYTES      = wps_pkg::PAT_BYTES;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1150;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 60;

  typedef struct packed {
    logic                       found;
    logic [wps_pkg::ADDR_W-1:0] addr;
  } scan_report_t;

  // DUT ports
  logic                           clk;
  logic                           rst;
  logic                           cfg_write_en;
  logic [wps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wps_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     data_byte;
  logic                           last_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic                           found;
  logic [wps_pkg::ADDR_W-1:0]     match_address;

  // Predictor copy of the registers
  logic [63:0]                 pat_value;
  logic [15:0]                 pat_care;
  logic [wps_pkg::LEN_W-1:0]   pat_len;
  logic [wps_pkg::ADDR_W-1:0]  region_base;
  logic [wps_pkg::ADDR_W-1:0]  report_offset;
  logic [wps_pkg::COUNT_W-1:0] target_occ;

  // Predictor copy of the scan state
  logic [7:0]                  recent_bytes [0:WIN_BYTES-2];
  logic [wps_pkg::ADDR_W-1:0]  scan_pos;
  logic [wps_pkg::COUNT_W-1:0] hits_counted;
  bit                          report_done;
  int                          window_fill;

  scan_report_t expected_reports [$];

  // Run control and bookkeeping
  bit send_gaps;
  bit stall_en;
  int hold_cycles;
  int fail_count;
  int bytes_taken;
  int reports_checked;
  int regions_sent;
  int reg_writes;
  int idle_cycles;

  wildcard_pattern_scan_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_address (match_address)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int active_len();
    return (pat_len > WIN_BYTES) ? WIN_BYTES : int'(pat_len);
  endfunction

  // A clear care bit turns that nibble into a wildcard
  function automatic bit nibble_match(input int idx, input logic [7:0] b);
    logic [7:0] pb;
    pb = pat_value[8*idx +: 8];
    if (pat_care[2*idx] && (b[3:0] != pb[3:0])) return 1'b0;
    if (pat_care[2*idx+1] && (b[7:4] != pb[7:4])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_scan();
    int i;
    for (i = 0; i < WIN_BYTES - 1; i++) recent_bytes[i] = 8'h00;
    scan_pos     = '0;
    hits_counted = '0;
    report_done  = 1'b0;
    window_fill  = 0;
  endfunction

  function automatic void reset_registers();
    pat_value     = '0;
    pat_care      = '0;
    pat_len       = 4'd1;
    region_base   = '0;
    report_offset = '0;
    target_occ    = '0;
    clear_scan();
  endfunction

  // One scanned byte in, zero or one expected report out
  function automatic void scan_byte(input logic [7:0] cur, input logic is_last);
    int           len;
    int           i;
    bit           hit;
    scan_report_t rep;
    len = active_len();
    if (window_fill < WIN_BYTES) window_fill++;
    if (len != 0 && window_fill >= len && !report_done) begin
      hit = nibble_match(len - 1, cur);
      for (i = 0; hit && i + 1 < len; i++)
        hit = nibble_match(i, recent_bytes[len - 2 - i]);
      if (hit) begin
        if (hits_counted == target_occ) begin
          rep.found = 1'b1;
          rep.addr  = region_base + (scan_pos - wps_pkg::ADDR_W'(len - 1)) + report_offset;
          expected_reports = {expected_reports, rep};
          report_done = 1'b1;
        end else if (hits_counted != wps_pkg::COUNT_MAX) begin
          hits_counted++;
        end
      end
    end
    if (is_last) begin
      if (!report_done) begin
        rep.found = 1'b0;
        rep.addr  = '0;
        expected_reports = {expected_reports, rep};
      end
      clear_scan();
    end else begin
      for (i = WIN_BYTES - 2; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
      recent_bytes[0] = cur;
      scan_pos++;
    end
  endfunction

  // ---------------------------------------------------------------- monitors

  // Input words feed the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      scan_byte(data_byte, last_byte);
      bytes_taken++;
    end
  end

  // Output words against the oldest expected report
  always @(posedge clk) begin
    scan_report_t exp_rep;
    if (!rst && out_valid && !out_stall) begin
      reports_checked++;
      if (expected_reports.size() == 0) begin
        $error("unexpected word: found=%0d match_address=%08h", found, match_address);
        fail_count++;
      end else begin
        exp_rep = expected_reports.pop_front();
        if (found !== exp_rep.found) begin
          $error("found: expected %0d, actual %0d", exp_rep.found, found);
          fail_count++;
        end
        if (match_address !== exp_rep.addr) begin
          $error("match_address: expected %08h, actual %08h", exp_rep.addr, match_address);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d reports outstanding",
               idle_cycles, expected_reports.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result receiver: random stall per word, plus an occasional long hold-off
  initial begin
    int n;
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        n = stall_en ? $urandom_range(0, 4) : 0;
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!(out_valid && !out_stall) && hold_cycles == 0);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // Offer one scanned byte and hold it until taken
  task automatic send_word(input logic [7:0] d, input logic is_last);
    int gap;
    gap = send_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= is_last;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Stop sending, drain all reports, then let the pipeline go quiet
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input wps_pkg::cfg_reg_t idx, input logic [63:0] val);
    settle_idle();
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    reg_writes++;
    case (idx)
      wps_pkg::REG_PATTERN_BYTES:     pat_value     = val;
      wps_pkg::REG_NIBBLE_CARE:       pat_care      = val[15:0];
      wps_pkg::REG_PATTERN_LENGTH:    pat_len       = val[wps_pkg::LEN_W-1:0];
      wps_pkg::REG_BASE_ADDRESS:      region_base   = val[wps_pkg::ADDR_W-1:0];
      wps_pkg::REG_MATCH_OFFSET:      report_offset = val[wps_pkg::ADDR_W-1:0];
      wps_pkg::REG_WANTED_OCCURRENCE: target_occ    = val[wps_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_bytes(input logic [7:0] seq [$]);
    int k;
    for (k = 0; k < seq.size(); k++) send_word(seq[k], k == seq.size() - 1);
    regions_sent++;
  endtask

  // A byte that satisfies pattern byte idx, wildcard nibbles random
  function automatic logic [7:0] make_hit_byte(input int idx);
    logic [7:0] b;
    b = 8'($urandom);
    if (pat_care[2*idx])   b[3:0] = pat_value[8*idx +: 4];
    if (pat_care[2*idx+1]) b[7:4] = pat_value[8*idx+4 +: 4];
    return b;
  endfunction

  // Random region of n bytes with planted pattern instances
  task automatic run_region(input int n, input int plants);
    logic [7:0] region_bytes [$];
    int         k;
    int         j;
    int         s;
    int         len;
    len = active_len();
    for (k = 0; k < n; k++) region_bytes = {region_bytes, 8'($urandom)};
    for (k = 0; k < plants; k++) begin
      if (len > 0 && n >= len) begin
        s = $urandom_range(0, n - len);
        for (j = 0; j < len; j++) region_bytes[s + j] = make_hit_byte(j);
      end
    end
    send_bytes(region_bytes);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // New random configuration; the first call writes every register
  task automatic randomize_setup(input bit write_all);
    logic [63:0] v;
    if (write_all || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = '1;
        default: v = {$urandom, $urandom};
      endcase
      write_reg(wps_pkg::REG_PATTERN_BYTES, v);
    end
    if (write_all || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 7))
        0:       v = 64'h0;
        1:       v = 64'hFFFF;
        2:       v = {48'h0, 16'($urandom) & 16'($urandom)};
        default: v = {48'h0, 16'($urandom)};
      endcase
      write_reg(wps_pkg::REG_NIBBLE_CARE, v);
    end
    if (write_all || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 15))
        0:       v = 64'd0;
        1:       v = 64'd15;
        2:       v = 64'($urandom_range(9, 15));
        3, 4:    v = 64'd8;
        5:       v = 64'd1;
        default: v = 64'($urandom_range(1, 8));
      endcase
      write_reg(wps_pkg::REG_PATTERN_LENGTH, v);
    end
    if (write_all || $urandom_range(0, 1))
      write_reg(wps_pkg::REG_BASE_ADDRESS, 64'(pick_addr()));
    if (write_all || $urandom_range(0, 1))
      write_reg(wps_pkg::REG_MATCH_OFFSET, 64'(pick_addr()));
    if (write_all || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0:       v = 64'hFFFF;
        1:       v = 64'($urandom_range(0, 65535));
        default: v = 64'($urandom_range(0, 3));
      endcase
      write_reg(wps_pkg::REG_WANTED_OCCURRENCE, v);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Reset defaults: length 1, every nibble wild, so each byte matches
  task automatic test_reset_defaults();
    send_bytes('{8'h00, 8'hFF});   // report on first byte, silent last byte
    send_bytes('{8'h5A});          // match on the last byte itself
  endtask

  // Full 8-byte exact pattern, address wraps through base plus offset
  task automatic test_exact_match();
    write_reg(wps_pkg::REG_PATTERN_BYTES, 64'h0123_4567_89AB_CDEF);
    write_reg(wps_pkg::REG_NIBBLE_CARE, 64'hFFFF);
    write_reg(wps_pkg::REG_PATTERN_LENGTH, 64'd8);
    write_reg(wps_pkg::REG_BASE_ADDRESS, 64'hFFFF_FFF0);
    write_reg(wps_pkg::REG_MATCH_OFFSET, 64'h0000_0020);
    send_bytes('{8'h00, 8'hEF, 8'hCD, 8'hAB, 8'h89, 8'h67, 8'h45, 8'h23, 8'h01, 8'hFF});
  endtask

  // High nibbles wild, overlapping matches, third one reported
  task automatic test_nibble_wildcards();
    write_reg(wps_pkg::REG_PATTERN_BYTES, 64'h0A0A);
    write_reg(wps_pkg::REG_NIBBLE_CARE, 64'h0005);
    write_reg(wps_pkg::REG_PATTERN_LENGTH, 64'd2);
    write_reg(wps_pkg::REG_BASE_ADDRESS, 64'h0000_1000);
    write_reg(wps_pkg::REG_MATCH_OFFSET, 64'h0);
    write_reg(wps_pkg::REG_WANTED_OCCURRENCE, 64'd2);
    send_bytes('{8'h1A, 8'h2A, 8'h3A, 8'hFA, 8'h55});
  endtask

  // Zero length never matches
  task automatic test_zero_length();
    write_reg(wps_pkg::REG_PATTERN_LENGTH, 64'd0);
    write_reg(wps_pkg::REG_NIBBLE_CARE, 64'h0);
    write_reg(wps_pkg::REG_WANTED_OCCURRENCE, 64'd0);
    send_bytes('{8'h00, 8'hFF});
  endtask

  // Length above the window clamps to 8; match completes on the last byte
  task automatic test_overlong_length();
    write_reg(wps_pkg::REG_PATTERN_LENGTH, 64'd15);
    write_reg(wps_pkg::REG_BASE_ADDRESS, 64'h0);
    write_reg(wps_pkg::REG_MATCH_OFFSET, 64'hFFFF_FFFF);
    send_bytes('{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88});
  endtask

  // Occurrence far beyond the region: found=0 on the last byte
  task automatic test_missing_occurrence();
    write_reg(wps_pkg::REG_PATTERN_LENGTH, 64'd1);
    write_reg(wps_pkg::REG_WANTED_OCCURRENCE, 64'hFFFF);
    send_bytes('{8'hA5, 8'h5A, 8'hC3});
  endtask

  // Random configurations, mostly seeded regions, some pure noise
  task automatic test_random_regions();
    int  regions;
    int  r;
    int  n;
    bit  first;
    first = 1'b1;
    while (bytes_taken < ITEM_TARGET) begin
      randomize_setup(first);
      first     = 1'b0;
      send_gaps = ($urandom_range(0, 3) != 0);
      stall_en  = ($urandom_range(0, 3) != 0);
      regions   = $urandom_range(3, 6);
      for (r = 0; r < regions; r++) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        if ($urandom_range(0, 9) == 0) run_region(n, 0);
        else run_region(n, $urandom_range(1, 3));
      end
    end
    send_gaps = 1'b1;
    stall_en  = 1'b1;
  endtask

  // Long receiver hold-off while one-byte regions keep arriving back to back
  task automatic test_backpressure();
    int k;
    write_reg(wps_pkg::REG_PATTERN_LENGTH, 64'd1);
    write_reg(wps_pkg::REG_NIBBLE_CARE, 64'h0);
    write_reg(wps_pkg::REG_WANTED_OCCURRENCE, 64'd0);
    write_reg(wps_pkg::REG_BASE_ADDRESS, 64'h0000_4000);
    send_gaps   = 1'b0;
    hold_cycles = HOLD_CYCLES;
    for (k = 0; k < 30; k++) send_bytes('{8'($urandom)});
    send_gaps = 1'b1;
    settle_idle();
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst          <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_index    <= wps_pkg::REG_PATTERN_BYTES;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    data_byte    <= 8'h00;
    last_byte    <= 1'b0;
    send_gaps       = 1'b1;
    stall_en        = 1'b1;
    hold_cycles     = 0;
    fail_count      = 0;
    bytes_taken     = 0;
    reports_checked = 0;
    regions_sent    = 0;
    reg_writes      = 0;
    idle_cycles     = 0;
    reset_registers();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_exact_match();
    test_nibble_wildcards();
    test_zero_length();
    test_overlong_length();
    test_missing_occurrence();
    test_random_regions();
    test_backpressure();

    settle_idle();
    repeat (6) @(posedge clk);
    $display("covered %0d bytes in %0d regions, %0d reports checked, %0d register writes",
             bytes_taken, regions_sent, reports_checked, reg_writes);
    $display("including wildcards, overlap, length clamp, address wrap and a long hold-off");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
